>>> design/md5_sha1_hash_engine_assert.svh
// Assertion macros shared by the hash engine checker.
// Depends on nothing; included by the checker file only.
`ifndef MD5_SHA1_HASH_ENGINE_ASSERT_SVH
`define MD5_SHA1_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MSHE_AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MSHE_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/mshe_pkg.sv
// Package for the MD5 / SHA-1 hash engine: types, state codes, round constants.
// Depends on nothing; imported by the round unit, block buffer and top level.
`timescale 1ns / 1ps
package mshe_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } mshe_words_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_EMIT
  } mshe_state_t;

  localparam logic ALG_MD5  = 1'b0;
  localparam logic ALG_SHA1 = 1'b1;

  localparam logic [31:0] INIT_H0 = 32'h67452301;
  localparam logic [31:0] INIT_H1 = 32'hEFCDAB89;
  localparam logic [31:0] INIT_H2 = 32'h98BADCFE;
  localparam logic [31:0] INIT_H3 = 32'h10325476;
  localparam logic [31:0] INIT_H4 = 32'hC3D2E1F0;

  localparam logic [31:0] SHA_K0 = 32'h5A827999;
  localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] MD5_LAST_ROUND = 7'd63;
  localparam logic [6:0] SHA_LAST_ROUND = 7'd79;
  localparam int COUNT_W = 61;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word index used by an MD5 round.
  function automatic logic [3:0] md5_g(input logic [6:0] r);
    logic [3:0] lo;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    md5_g = lo;
      2'd1:    md5_g = 4'((lo << 2) + lo + 4'd1);
      2'd2:    md5_g = 4'((lo << 1) + lo + 4'd5);
      default: md5_g = 4'((lo << 3) - lo);
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    rotl = t[63:32];
  endfunction

endpackage

>>> design/mshe_round.sv
// Shared round unit: one MD5 or SHA-1 compression round per use.
// Depends on mshe_pkg.
`timescale 1ns / 1ps
module mshe_round
  import mshe_pkg::*;
(
  input  logic        sha_i,
  input  logic [6:0]  round_i,
  input  mshe_words_t st_i,
  input  logic [31:0] word_i,
  output mshe_words_t st_o
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] sum;

  always_comb begin
    st_o = st_i;
    f = '0;
    k = '0;
    sum = '0;
    if (sha_i) begin
      if (round_i < 7'd20) begin
        f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
        k = SHA_K0;
      end else if (round_i < 7'd40) begin
        f = st_i.b ^ st_i.c ^ st_i.d;
        k = SHA_K1;
      end else if (round_i < 7'd60) begin
        f = (st_i.b & st_i.c) | (st_i.b & st_i.d) | (st_i.c & st_i.d);
        k = SHA_K2;
      end else begin
        f = st_i.b ^ st_i.c ^ st_i.d;
        k = SHA_K3;
      end
      sum = rotl(st_i.a, 5'd5) + f + st_i.e + k + word_i;
      st_o.e = st_i.d;
      st_o.d = st_i.c;
      st_o.c = rotl(st_i.b, 5'd30);
      st_o.b = st_i.a;
      st_o.a = sum;
    end else begin
      case (round_i[5:4])
        2'd0:    f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
        2'd1:    f = (st_i.d & st_i.b) | (~st_i.d & st_i.c);
        2'd2:    f = st_i.b ^ st_i.c ^ st_i.d;
        default: f = st_i.c ^ (st_i.b | ~st_i.d);
      endcase
      k = MD5_K[round_i[5:0]];
      sum = f + st_i.a + k + word_i;
      st_o.a = st_i.d;
      st_o.d = st_i.c;
      st_o.c = st_i.b;
      st_o.b = st_i.b + rotl(sum, MD5_S[{round_i[5:4], round_i[1:0]}]);
    end
  end

endmodule

>>> design/mshe_msgbuf.sv
// Block buffer: sixteen 32-bit words filled a byte at a time, with the
// SHA-1 message schedule shift. Depends on mshe_pkg.
`timescale 1ns / 1ps
module mshe_msgbuf
  import mshe_pkg::*;
(
  input  logic        clk,
  input  logic        sha_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_pos_i,
  input  logic [7:0]  wr_byte_i,
  input  logic        shift_i,
  input  logic [3:0]  rd_idx_i,
  output logic [31:0] rd_word_o
);

  logic [31:0] msg_r [16];
  logic [1:0]  lane;
  logic [31:0] w_new;

  assign lane  = sha_i ? ~wr_pos_i[1:0] : wr_pos_i[1:0];
  assign w_new = rotl(msg_r[13] ^ msg_r[8] ^ msg_r[2] ^ msg_r[0], 5'd1);

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      msg_r[wr_pos_i[5:2]][{lane, 3'b000} +: 8] <= wr_byte_i;
    end else if (shift_i) begin
      for (int i = 0; i < 15; i++) begin
        msg_r[i] <= msg_r[i + 1];
      end
      msg_r[15] <= w_new;
    end
  end

  assign rd_word_o = msg_r[rd_idx_i];

endmodule

>>> design/md5_sha1_hash_engine.sv
// MD5 / SHA-1 streaming hash engine. Byte beats are taken only while idle; a
// beat that fills a block starts a compression: load, one round per cycle
// in the shared round unit, and the chaining add. A last beat writes the
// padding bytes up to the block end, runs one or two compressions, then
// one output beat per digest word. Reset is synchronous, active low, with no pass.
`timescale 1ns / 1ps
module md5_sha1_hash_engine
  import mshe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_algorithm_select
);

  mshe_state_t state_r, state_nxt;

  logic               algo_r;
  logic [31:0]        chain_r [5];
  logic [COUNT_W-1:0] count_r;
  logic [6:0]         round_r;
  mshe_words_t        st_r, st_next;
  logic [5:0]         pad_pos_r;
  logic               pad_first_r, pad_extra_r, pad_final_r, pend_pad_r;
  logic [2:0]         emit_idx_r;

  logic in_fire, out_fire, cfg_fire;
  logic full_blk;
  logic [5:0] pos0;
  logic last_round, last_emit;
  logic [63:0] bit_len;
  logic [7:0]  pad_byte;
  logic [2:0]  len_j;
  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic [31:0] msg_word;
  logic [31:0] h;
  mshe_words_t chain_w;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign cfg_fire = cfg_valid && cfg_ready;

  // A byte that lands in the last slot of the block starts a compression.
  assign full_blk   = in_byte_present && (count_r[5:0] == 6'd63);
  assign pos0       = 6'(count_r[5:0] + {5'd0, in_byte_present});
  assign last_round = round_r == (algo_r ? SHA_LAST_ROUND : MD5_LAST_ROUND);
  assign last_emit  = emit_idx_r == (algo_r ? 3'd4 : 3'd3);

  // Padding bytes: the marker, zeros, and in the final block the bit length.
  assign bit_len = {count_r, 3'b000};
  assign len_j   = algo_r ? ~pad_pos_r[2:0] : pad_pos_r[2:0];
  always_comb begin
    if (pad_first_r) begin
      pad_byte = PAD_BYTE;
    end else if (!pad_extra_r && pad_pos_r[5:3] == 3'd7) begin
      pad_byte = bit_len[{len_j, 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  assign wr_en   = (in_fire && in_byte_present) || (state_r == S_PAD);
  assign wr_pos  = (state_r == S_PAD) ? pad_pos_r : count_r[5:0];
  assign wr_byte = (state_r == S_PAD) ? pad_byte : in_data_byte;

  mshe_msgbuf u_buf (
    .clk       (clk),
    .sha_i     (algo_r),
    .wr_en_i   (wr_en),
    .wr_pos_i  (wr_pos),
    .wr_byte_i (wr_byte),
    .shift_i   (state_r == S_ROUND && algo_r),
    .rd_idx_i  (algo_r ? 4'd0 : md5_g(round_r)),
    .rd_word_o (msg_word)
  );

  mshe_round u_round (
    .sha_i   (algo_r),
    .round_i (round_r),
    .st_i    (st_r),
    .word_i  (msg_word),
    .st_o    (st_next)
  );

  assign chain_w = '{a: chain_r[0], b: chain_r[1], c: chain_r[2],
                     d: chain_r[3], e: chain_r[4]};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (full_blk) begin
            state_nxt = S_LOAD;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (pad_pos_r == 6'd63) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD:  state_nxt = S_ROUND;
      S_ROUND: begin
        if (last_round) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (pad_final_r) begin
          state_nxt = S_EMIT;
        end else if (pend_pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_fire && last_emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake outputs. Configuration is only written while idle, and a
  // pending configuration beat holds off the input for that cycle.
  always_comb begin
    in_ready  = (state_r == S_IDLE) && !cfg_valid;
    out_valid = (state_r == S_EMIT);
    cfg_ready = (state_r == S_IDLE);
  end

  // MD5 digest bytes come out of each chaining word low byte first.
  assign h = chain_r[emit_idx_r];
  assign out_digest_word = algo_r ? h : {h[7:0], h[15:8], h[23:16], h[31:24]};
  assign out_word_index  = emit_idx_r;
  assign out_last_word   = last_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      algo_r      <= ALG_SHA1;
      chain_r     <= '{INIT_H0, INIT_H1, INIT_H2, INIT_H3, INIT_H4};
      count_r     <= '0;
      round_r     <= '0;
      pad_pos_r   <= '0;
      pad_first_r <= 1'b0;
      pad_extra_r <= 1'b0;
      pad_final_r <= 1'b0;
      pend_pad_r  <= 1'b0;
      emit_idx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_byte_present) begin
              count_r <= count_r + 1'b1;
            end
            if (in_last) begin
              pend_pad_r  <= 1'b1;
              pad_pos_r   <= pos0;
              pad_first_r <= 1'b1;
              pad_extra_r <= (pos0[5:3] == 3'd7);
              pad_final_r <= 1'b0;
            end
          end
        end
        S_PAD: begin
          pad_pos_r   <= pad_pos_r + 1'b1;
          pad_first_r <= 1'b0;
          if (pad_pos_r == 6'd63) begin
            if (pad_extra_r) begin
              pad_extra_r <= 1'b0;
            end else begin
              pad_final_r <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          st_r    <= chain_w;
          round_r <= '0;
        end
        S_ROUND: begin
          st_r    <= st_next;
          round_r <= round_r + 1'b1;
        end
        S_ADD: begin
          chain_r[0] <= chain_r[0] + st_r.a;
          chain_r[1] <= chain_r[1] + st_r.b;
          chain_r[2] <= chain_r[2] + st_r.c;
          chain_r[3] <= chain_r[3] + st_r.d;
          chain_r[4] <= chain_r[4] + st_r.e;
        end
        S_EMIT: begin
          if (out_fire) begin
            if (last_emit) begin
              emit_idx_r  <= '0;
              pend_pad_r  <= 1'b0;
              pad_final_r <= 1'b0;
              count_r     <= '0;
              chain_r     <= '{INIT_H0, INIT_H1, INIT_H2, INIT_H3, INIT_H4};
            end else begin
              emit_idx_r <= emit_idx_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
      // A mode write abandons any message and restarts the chain.
      if (cfg_fire) begin
        algo_r  <= cfg_algorithm_select;
        count_r <= '0;
        chain_r <= '{INIT_H0, INIT_H1, INIT_H2, INIT_H3, INIT_H4};
      end
    end
  end

endmodule

>>> design/mshe_checker.sv
// Port-level checker for the hash engine, bound to the top level.
// Depends on md5_sha1_hash_engine_assert.svh.
`timescale 1ns / 1ps
`include "md5_sha1_hash_engine_assert.svh"
module mshe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  logic       out_fire;
  logic       idx_end;
  logic [2:0] idx_inc;

  assign out_fire = out_valid && out_ready;
  assign idx_end  = (out_word_index == 3'd3) || (out_word_index == 3'd4);
  assign idx_inc  = 3'(out_word_index + 3'd1);

  `MSHE_AST_IMPL(a_no_overlap, out_valid, !in_ready)
  `MSHE_AST_IMPL(a_last_idx, out_valid && out_last_word, idx_end)
  `MSHE_AST_NEXT(a_end_digest, out_fire && out_last_word, !out_valid)
  `MSHE_AST_NEXT(a_idx_step, out_fire && !out_last_word, out_valid && out_word_index == $past(idx_inc))

endmodule

bind md5_sha1_hash_engine mshe_checker u_mshe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_word_index (out_word_index),
  .out_last_word  (out_last_word)
);
